### rtl/lc3x_pkg.sv
package lc3x_pkg;

    // Word memory depth; a power of two, so the address is taken modulo it by truncation
    localparam int MEM_WORDS = 65536;
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    localparam int RF_DEPTH = 8;
    localparam int RF_AW    = $clog2(RF_DEPTH);

    localparam logic [15:0]      PC_RESET = 16'h3000;
    localparam logic [15:0]      PC_INDEX = 16'd8;
    localparam logic [7:0]       HALT_VEC = 8'h25;
    localparam logic [RF_AW-1:0] LINK_REG = RF_AW'(7);

    localparam logic [2:0] CC_N = 3'b100;
    localparam logic [2:0] CC_Z = 3'b010;
    localparam logic [2:0] CC_P = 3'b001;

    typedef enum logic [1:0]
    {
        FN_EXEC,
        FN_MEM_WR,
        FN_REG_WR,
        FN_MEM_RD
    } func_t;

    typedef enum logic [3:0]
    {
        OP_BR,
        OP_ADD,
        OP_LD,
        OP_ST,
        OP_JSR,
        OP_AND,
        OP_LDR,
        OP_STR,
        OP_RTI,
        OP_NOT,
        OP_LDI,
        OP_STI,
        OP_JMP,
        OP_RES,
        OP_LEA,
        OP_TRAP
    } opcode_t;

    typedef enum logic [1:0]
    {
        STS_OK,
        STS_ILLEGAL,
        STS_TRAP
    } status_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_EXE,
        S_MEM1,
        S_MEM2
    } state_t;

    typedef struct packed
    {
        logic             en;
        logic [RF_AW-1:0] addr_a;
        logic [RF_AW-1:0] addr_b;
    } rf_rd_t;

    typedef struct packed
    {
        logic             en;
        logic [RF_AW-1:0] addr;
        logic [15:0]      data;
    } rf_wr_t;

    function automatic logic [15:0] sext5(input logic [4:0] v);
        return {{11{v[4]}}, v};
    endfunction

    function automatic logic [15:0] sext6(input logic [5:0] v);
        return {{10{v[5]}}, v};
    endfunction

    function automatic logic [15:0] sext9(input logic [8:0] v);
        return {{7{v[8]}}, v};
    endfunction

    function automatic logic [15:0] sext11(input logic [10:0] v);
        return {{5{v[10]}}, v};
    endfunction

    function automatic logic [2:0] cc_of(input logic [15:0] v);
        logic [2:0] cc;
        if (v[15])
            cc = CC_N;
        else if (v == 16'd0)
            cc = CC_Z;
        else
            cc = CC_P;
        return cc;
    endfunction

    function automatic logic [MEM_AW-1:0] mem_idx(input logic [15:0] a);
        return a[MEM_AW-1:0];
    endfunction

endpackage

### rtl/lc3_instruction_executor.sv
// From input transfer to result an item passes the input holding register, S_EXE and the
// output register; LD, LDR, STI and memory reads also pass S_MEM1, and LDI S_MEM2 as well
// (single memory port). One further item is held at the input while another executes;
// a new item starts once the last has finished and its result has entered the output register.
// Reset: R0-R7 read zero, PC 0x3000, condition code Z, halt clear, no pending items.
// Word memory contents are undefined after reset and are not cleared.
module lc3_instruction_executor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [15:0] instruction,
    input  logic [15:0] addr,
    input  logic [15:0] data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] pc_value,
    output logic [2:0]  cond_code,
    output logic        halted,
    output logic [15:0] dest_value,
    output logic [15:0] read_data
);

    // Input holding stage
    logic                  in_valid_reg;
    lc3x_pkg::func_t       in_func_reg;
    logic [15:0]           in_ir_reg;
    logic [15:0]           in_addr_reg;
    logic [15:0]           in_data_reg;

    // Item at work
    lc3x_pkg::func_t       func_reg;
    logic [15:0]           ir_reg;
    logic [15:0]           addr_reg;
    logic [15:0]           data_reg;

    lc3x_pkg::state_t      state_reg;
    lc3x_pkg::state_t      state_next;
    lc3x_pkg::state_t      state_c;

    logic [15:0]           pc_reg;
    logic [15:0]           pc_next;
    logic [2:0]            cc_reg;
    logic [2:0]            cc_next;
    logic                  halt_reg;
    logic                  halt_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    lc3x_pkg::status_t     status_reg;
    logic [15:0]           dv_reg;
    logic [15:0]           rd_reg;

    logic                  take;
    logic                  in_accept;
    logic                  out_free;
    logic                  fin;
    logic                  commit;

    lc3x_pkg::rf_rd_t      rf_rd;
    lc3x_pkg::rf_wr_t      rf_wr;
    logic [15:0]           rf_a;
    logic [15:0]           rf_b;
    logic                  rf_we_c;
    logic [lc3x_pkg::RF_AW-1:0] rf_waddr_c;
    logic [15:0]           rf_wdata_c;

    logic                  mem_rd_c;
    logic                  mem_wr_c;
    logic [lc3x_pkg::MEM_AW-1:0] mem_addr_c;
    logic [15:0]           mem_wdata_c;
    logic                  mem_en;
    logic                  mem_we;
    logic [15:0]           mem_rdata;

    logic [15:0]           pc_c;
    logic [2:0]            cc_c;
    logic                  halt_c;
    lc3x_pkg::status_t     sts_c;
    logic [15:0]           dv_c;
    logic [15:0]           rd_c;

    lc3x_pkg::opcode_t     op;
    lc3x_pkg::opcode_t     in_op;
    logic [lc3x_pkg::RF_AW-1:0] dr;
    logic [15:0]           pcoff9;
    logic [15:0]           pcoff11;
    logic [15:0]           base6;
    logic [15:0]           opnd2;
    logic [15:0]           alu_v;

    assign in_stall  = in_valid_reg;
    assign in_accept = in_valid && !in_valid_reg;
    assign take      = (state_reg == lc3x_pkg::S_IDLE) && in_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign commit    = fin && out_free;

    assign op      = lc3x_pkg::opcode_t'(ir_reg[15:12]);
    assign in_op   = lc3x_pkg::opcode_t'(in_ir_reg[15:12]);
    assign dr      = ir_reg[11:9];
    assign pcoff9  = pc_reg + lc3x_pkg::sext9(ir_reg[8:0]);
    assign pcoff11 = pc_reg + lc3x_pkg::sext11(ir_reg[10:0]);
    assign base6   = rf_a + lc3x_pkg::sext6(ir_reg[5:0]);
    assign opnd2   = ir_reg[5] ? lc3x_pkg::sext5(ir_reg[4:0]) : rf_b;
    assign alu_v   = (op == lc3x_pkg::OP_ADD) ? (rf_a + opnd2) : (rf_a & opnd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_accept)
            in_valid_reg <= 1'b1;
        else if (take)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_func_reg <= lc3x_pkg::func_t'(func);
            in_ir_reg   <= instruction;
            in_addr_reg <= addr;
            in_data_reg <= data;
        end
        if (take)
        begin
            func_reg <= in_func_reg;
            ir_reg   <= in_ir_reg;
            addr_reg <= in_addr_reg;
            data_reg <= in_data_reg;
        end
        if (commit)
        begin
            status_reg <= sts_c;
            dv_reg     <= dv_c;
            rd_reg     <= rd_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lc3x_pkg::S_IDLE;
            pc_reg        <= lc3x_pkg::PC_RESET;
            cc_reg        <= lc3x_pkg::CC_Z;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            cc_reg        <= cc_next;
            halt_reg      <= halt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Register file read is issued as the item is taken; stores read their source on port b
    always_comb
    begin
        rf_rd.en     = take;
        rf_rd.addr_a = in_ir_reg[8:6];
        if (in_op inside {lc3x_pkg::OP_ST, lc3x_pkg::OP_STI, lc3x_pkg::OP_STR})
            rf_rd.addr_b = in_ir_reg[11:9];
        else
            rf_rd.addr_b = in_ir_reg[2:0];
    end

    always_comb
    begin
        state_c     = state_reg;
        fin         = 1'b0;
        rf_we_c     = 1'b0;
        rf_waddr_c  = dr;
        rf_wdata_c  = 16'd0;
        mem_rd_c    = 1'b0;
        mem_wr_c    = 1'b0;
        mem_addr_c  = lc3x_pkg::mem_idx(pcoff9);
        mem_wdata_c = rf_b;
        pc_c        = pc_reg;
        cc_c        = cc_reg;
        halt_c      = halt_reg;
        sts_c       = lc3x_pkg::STS_OK;
        dv_c        = 16'd0;
        rd_c        = 16'd0;

        case (state_reg)
            lc3x_pkg::S_IDLE:
            begin
                if (take)
                    state_c = lc3x_pkg::S_EXE;
            end

            lc3x_pkg::S_EXE:
            begin
                case (func_reg)
                    lc3x_pkg::FN_EXEC:
                    begin
                        case (op)
                            lc3x_pkg::OP_ADD, lc3x_pkg::OP_AND:
                            begin
                                fin        = 1'b1;
                                rf_we_c    = 1'b1;
                                rf_wdata_c = alu_v;
                                cc_c       = lc3x_pkg::cc_of(alu_v);
                                dv_c       = alu_v;
                            end
                            lc3x_pkg::OP_NOT:
                            begin
                                fin        = 1'b1;
                                rf_we_c    = 1'b1;
                                rf_wdata_c = ~rf_a;
                                cc_c       = lc3x_pkg::cc_of(~rf_a);
                                dv_c       = ~rf_a;
                            end
                            lc3x_pkg::OP_BR:
                            begin
                                fin = 1'b1;
                                if ((ir_reg[11:9] & cc_reg) != 3'd0)
                                    pc_c = pcoff9;
                            end
                            lc3x_pkg::OP_JMP:
                            begin
                                fin  = 1'b1;
                                pc_c = rf_a;
                            end
                            lc3x_pkg::OP_JSR:
                            begin
                                // base register was read before the link write
                                fin        = 1'b1;
                                rf_we_c    = 1'b1;
                                rf_waddr_c = lc3x_pkg::LINK_REG;
                                rf_wdata_c = pc_reg;
                                dv_c       = pc_reg;
                                pc_c       = ir_reg[11] ? pcoff11 : rf_a;
                            end
                            lc3x_pkg::OP_LEA:
                            begin
                                fin        = 1'b1;
                                rf_we_c    = 1'b1;
                                rf_wdata_c = pcoff9;
                                cc_c       = lc3x_pkg::cc_of(pcoff9);
                                dv_c       = pcoff9;
                            end
                            lc3x_pkg::OP_LD, lc3x_pkg::OP_LDI, lc3x_pkg::OP_STI:
                            begin
                                mem_rd_c = 1'b1;
                                state_c  = lc3x_pkg::S_MEM1;
                            end
                            lc3x_pkg::OP_LDR:
                            begin
                                mem_rd_c   = 1'b1;
                                mem_addr_c = lc3x_pkg::mem_idx(base6);
                                state_c    = lc3x_pkg::S_MEM1;
                            end
                            lc3x_pkg::OP_ST:
                            begin
                                fin      = 1'b1;
                                mem_wr_c = 1'b1;
                                dv_c     = rf_b;
                            end
                            lc3x_pkg::OP_STR:
                            begin
                                fin        = 1'b1;
                                mem_wr_c   = 1'b1;
                                mem_addr_c = lc3x_pkg::mem_idx(base6);
                                dv_c       = rf_b;
                            end
                            lc3x_pkg::OP_TRAP:
                            begin
                                fin        = 1'b1;
                                rf_we_c    = 1'b1;
                                rf_waddr_c = lc3x_pkg::LINK_REG;
                                rf_wdata_c = pc_reg;
                                dv_c       = pc_reg;
                                if (ir_reg[7:0] == lc3x_pkg::HALT_VEC)
                                    halt_c = 1'b1;
                                else
                                    sts_c = lc3x_pkg::STS_TRAP;
                            end
                            default:
                            begin
                                fin   = 1'b1;
                                sts_c = lc3x_pkg::STS_ILLEGAL;
                            end
                        endcase
                    end

                    lc3x_pkg::FN_MEM_WR:
                    begin
                        fin         = 1'b1;
                        mem_wr_c    = 1'b1;
                        mem_addr_c  = lc3x_pkg::mem_idx(addr_reg);
                        mem_wdata_c = data_reg;
                        dv_c        = data_reg;
                    end

                    lc3x_pkg::FN_REG_WR:
                    begin
                        fin = 1'b1;
                        if (addr_reg < lc3x_pkg::PC_INDEX)
                        begin
                            rf_we_c    = 1'b1;
                            rf_waddr_c = addr_reg[lc3x_pkg::RF_AW-1:0];
                            rf_wdata_c = data_reg;
                            dv_c       = data_reg;
                        end
                        else if (addr_reg == lc3x_pkg::PC_INDEX)
                        begin
                            pc_c = data_reg;
                            dv_c = data_reg;
                        end
                    end

                    default:
                    begin
                        mem_rd_c   = 1'b1;
                        mem_addr_c = lc3x_pkg::mem_idx(addr_reg);
                        state_c    = lc3x_pkg::S_MEM1;
                    end
                endcase
            end

            lc3x_pkg::S_MEM1:
            begin
                if (func_reg == lc3x_pkg::FN_MEM_RD)
                begin
                    fin  = 1'b1;
                    rd_c = mem_rdata;
                end
                else
                begin
                    case (op)
                        lc3x_pkg::OP_LDI:
                        begin
                            // follow the pointer
                            mem_rd_c   = 1'b1;
                            mem_addr_c = lc3x_pkg::mem_idx(mem_rdata);
                            state_c    = lc3x_pkg::S_MEM2;
                        end
                        lc3x_pkg::OP_STI:
                        begin
                            fin        = 1'b1;
                            mem_wr_c   = 1'b1;
                            mem_addr_c = lc3x_pkg::mem_idx(mem_rdata);
                            dv_c       = rf_b;
                        end
                        default:
                        begin
                            fin        = 1'b1;
                            rf_we_c    = 1'b1;
                            rf_wdata_c = mem_rdata;
                            cc_c       = lc3x_pkg::cc_of(mem_rdata);
                            dv_c       = mem_rdata;
                        end
                    endcase
                end
            end

            lc3x_pkg::S_MEM2:
            begin
                fin        = 1'b1;
                rf_we_c    = 1'b1;
                rf_wdata_c = mem_rdata;
                cc_c       = lc3x_pkg::cc_of(mem_rdata);
                dv_c       = mem_rdata;
            end

            default:
            begin
                state_c = lc3x_pkg::S_IDLE;
            end
        endcase
    end

    // Hold a finished item until the output register can take it
    always_comb
    begin
        if (fin)
            state_next = out_free ? lc3x_pkg::S_IDLE : state_reg;
        else
            state_next = state_c;

        pc_next        = commit ? pc_c : pc_reg;
        cc_next        = commit ? cc_c : cc_reg;
        halt_next      = commit ? halt_c : halt_reg;
        out_valid_next = commit || (out_valid_reg && out_stall);

        rf_wr.en   = rf_we_c && commit;
        rf_wr.addr = rf_waddr_c;
        rf_wr.data = rf_wdata_c;

        mem_we = mem_wr_c && commit;
        mem_en = mem_rd_c || mem_we;
    end

    lc3x_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd     (rf_rd),
        .wr     (rf_wr),
        .data_a (rf_a),
        .data_b (rf_b)
    );

    lc3x_ram #(
        .DEPTH (lc3x_pkg::MEM_WORDS),
        .WIDTH (16)
    ) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr_c),
        .wdata (mem_wdata_c),
        .rdata (mem_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign pc_value   = pc_reg;
    assign cond_code  = cc_reg;
    assign halted     = halt_reg;
    assign dest_value = dv_reg;
    assign read_data  = rd_reg;

`ifndef SYNTHESIS
    a_rf_write_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        rf_wr.en |=> state_reg == lc3x_pkg::S_IDLE)
        else $error("register file written outside item completion");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(halt_reg))
        else $error("halt flag cleared without reset");

    a_second_read_ldi: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lc3x_pkg::S_MEM2 |->
            (func_reg == lc3x_pkg::FN_EXEC && op == lc3x_pkg::OP_LDI))
        else $error("second memory read for an item other than LDI");

    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> !(out_valid_reg && out_stall))
        else $error("result completed while output register held");
`endif

endmodule

### rtl/lc3x_ram.sv
module lc3x_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/lc3x_regfile.sv
module lc3x_regfile (
    input  logic            clk,
    input  logic            rst_n,
    input  lc3x_pkg::rf_rd_t rd,
    input  lc3x_pkg::rf_wr_t wr,
    output logic [15:0]     data_a,
    output logic [15:0]     data_b
);

    logic [15:0]                   mem [lc3x_pkg::RF_DEPTH];
    logic [lc3x_pkg::RF_DEPTH-1:0] vld_reg;
    logic [15:0]                   data_a_reg;
    logic [15:0]                   data_b_reg;

    // An entry not yet written since reset reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (wr.en)
            vld_reg[wr.addr] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
        if (rd.en)
        begin
            data_a_reg <= vld_reg[rd.addr_a] ? mem[rd.addr_a] : 16'd0;
            data_b_reg <= vld_reg[rd.addr_b] ? mem[rd.addr_b] : 16'd0;
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule
